>>> rtl/pipt_pkg.sv
// Shared types and constants for the point-in-polygon test unit.
package pipt_pkg;

  localparam int COORD_W     = 20;
  localparam int DIFF_W      = COORD_W + 1;
  localparam int PROD_W      = 2 * DIFF_W;
  localparam int VTX_W       = 2 * COORD_W;
  localparam int MIN_VERTICES = 3;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_TEST   = 2'd2
  } pipt_op_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_WALK,
    BK_DRAIN
  } pipt_bk_state_t;

endpackage

>>> rtl/pipt_if.sv
// Valid/ready channel interfaces for the input and result transactions.
interface pipt_in_if import pipt_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic [1:0]                opcode;
  logic signed [COORD_W-1:0] coord_x;
  logic signed [COORD_W-1:0] coord_y;

  modport source (output valid, opcode, coord_x, coord_y, input ready);
  modport sink   (input valid, opcode, coord_x, coord_y, output ready);
endinterface

interface pipt_out_if;
  logic valid;
  logic ready;
  logic inside_res;
  logic too_few;
  logic overflowed;

  modport source (output valid, inside_res, too_few, overflowed, input ready);
  modport sink   (input valid, inside_res, too_few, overflowed, output ready);
endinterface

>>> rtl/pipt_ram.sv
// Generic simple dual-port RAM, one write port, one registered read port.
module pipt_ram #(
  parameter int W     = 40,
  parameter int DEPTH = 256,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/pipt_fifo.sv
// Two-entry queue between the front end and the edge walker.
module pipt_fifo #(
  parameter int W = 50
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic         valid,
  output logic [W-1:0] dout
);

  logic [W-1:0] mem_r [2];
  logic         wp_r, wp_nxt;
  logic         rp_r, rp_nxt;
  logic [1:0]   cnt_r, cnt_nxt;
  logic         do_push, do_pop;

  assign full    = (cnt_r == 2'd2);
  assign valid   = (cnt_r != 2'd0);
  assign dout    = mem_r[rp_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_comb begin
    wp_nxt  = do_push ? ~wp_r : wp_r;
    rp_nxt  = do_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= din;
    end
  end

endmodule

>>> rtl/pipt_front.sv
// Front end: accepts transactions, maintains the vertex store and queues tests.
module pipt_front import pipt_pkg::*; #(
  parameter int MAX_VERTICES = 256,
  localparam int CNT_W = $clog2(MAX_VERTICES + 1),
  localparam int AW    = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1,
  localparam int QW    = 1 + CNT_W + VTX_W
) (
  input  logic             clk,
  input  logic             rst_n,
  pipt_in_if.sink          in_ch,
  input  logic             back_busy,
  input  logic             q_full,
  input  logic             q_valid,
  output logic             q_push,
  output logic [QW-1:0]    q_din,
  output logic             ram_we,
  output logic [AW-1:0]    ram_waddr,
  output logic [VTX_W-1:0] ram_wdata
);

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             ovf_r, ovf_nxt;
  logic             store_idle;

  assign store_idle = !back_busy && !q_valid;
  assign q_din      = {ovf_r, count_r, in_ch.coord_y, in_ch.coord_x};
  assign ram_waddr  = count_r[AW-1:0];
  assign ram_wdata  = {in_ch.coord_y, in_ch.coord_x};

  always_comb begin
    in_ch.ready = 1'b1;
    q_push      = 1'b0;
    ram_we      = 1'b0;
    count_nxt   = count_r;
    ovf_nxt     = ovf_r;
    case (in_ch.opcode)
      OP_TEST: begin
        in_ch.ready = !q_full;
        q_push      = in_ch.valid && !q_full;
      end
      OP_CLEAR: begin
        in_ch.ready = store_idle;
        if (in_ch.valid && store_idle) begin
          count_nxt = '0;
          ovf_nxt   = 1'b0;
        end
      end
      OP_APPEND: begin
        in_ch.ready = store_idle;
        if (in_ch.valid && store_idle) begin
          if (count_r < CNT_W'(MAX_VERTICES)) begin
            ram_we    = 1'b1;
            count_nxt = count_r + CNT_W'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
        end
      end
      default: begin
        in_ch.ready = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else begin
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_VERTICES))
    else $error("vertex count above capacity");

  a_store_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (!back_busy && !q_valid && !ovf_r))
    else $error("vertex store written during a pending test");

  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ovf_r) |-> (count_r == CNT_W'(MAX_VERTICES)))
    else $error("overflow flagged below capacity");

endmodule

>>> rtl/pipt_back.sv
// Edge walker: reads each stored vertex once and accumulates crossing parity.
module pipt_back import pipt_pkg::*; #(
  parameter int MAX_VERTICES = 256,
  localparam int CNT_W = $clog2(MAX_VERTICES + 1),
  localparam int AW    = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1,
  localparam int QW    = 1 + CNT_W + VTX_W
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  logic [QW-1:0]    q_dout,
  output logic             q_pop,
  output logic             busy,
  output logic [AW-1:0]    ram_raddr,
  input  logic [VTX_W-1:0] ram_rdata,
  pipt_out_if.source       out_ch
);

  pipt_bk_state_t state_r, state_nxt;

  logic signed [COORD_W-1:0] q_x, q_y;
  logic [CNT_W-1:0]          q_cnt;
  logic                      q_ovf;

  logic [CNT_W-1:0] iss_r, iss_nxt;
  logic [CNT_W-1:0] n_r, n_nxt;
  logic signed [COORD_W-1:0] px_r, px_nxt, py_r, py_nxt;
  logic             snap_ovf_r, snap_ovf_nxt;
  logic             issue;

  logic rd_vld_r, rd_first_r, rd_last_r;

  logic signed [COORD_W-1:0] cur_x, cur_y;
  logic signed [COORD_W-1:0] first_x_r, first_y_r, prev_x_r, prev_y_r;
  logic close_r;

  logic                      e_vld, e_last;
  logic signed [COORD_W-1:0] ax, ay, bx, by;

  logic                     d_vld_r, d_last_r, d_cross_r, d_neg_r;
  logic signed [DIFF_W-1:0] d_dx_r, d_aby_r, d_abx_r, d_dyp_r;

  logic                     m_vld_r, m_last_r, m_cross_r, m_neg_r;
  logic signed [PROD_W-1:0] m_p1_r, m_p2_r;

  logic flip;
  logic par_r, par_nxt;

  logic out_vld_r, out_vld_nxt;
  logic out_ins_r, out_ins_nxt;
  logic out_few_r, out_few_nxt;
  logic out_ovf_r, out_ovf_nxt;

  assign q_x   = q_dout[COORD_W-1:0];
  assign q_y   = q_dout[COORD_W +: COORD_W];
  assign q_cnt = q_dout[VTX_W +: CNT_W];
  assign q_ovf = q_dout[QW-1];

  assign busy      = (state_r != BK_IDLE);
  assign ram_raddr = iss_r[AW-1:0];
  assign issue     = (state_r == BK_WALK);
  assign flip      = m_cross_r && (m_neg_r ? (m_p1_r > m_p2_r) : (m_p1_r < m_p2_r));

  assign out_ch.valid      = out_vld_r;
  assign out_ch.inside_res = out_ins_r;
  assign out_ch.too_few    = out_few_r;
  assign out_ch.overflowed = out_ovf_r;

  always_comb begin
    state_nxt    = state_r;
    iss_nxt      = iss_r;
    n_nxt        = n_r;
    px_nxt       = px_r;
    py_nxt       = py_r;
    snap_ovf_nxt = snap_ovf_r;
    par_nxt      = par_r;
    q_pop        = 1'b0;
    out_vld_nxt  = out_vld_r && !out_ch.ready;
    out_ins_nxt  = out_ins_r;
    out_few_nxt  = out_few_r;
    out_ovf_nxt  = out_ovf_r;
    case (state_r)
      BK_IDLE: begin
        if (q_valid && !out_vld_r) begin
          q_pop = 1'b1;
          if (q_cnt < CNT_W'(MIN_VERTICES)) begin
            out_vld_nxt = 1'b1;
            out_ins_nxt = 1'b0;
            out_few_nxt = 1'b1;
            out_ovf_nxt = q_ovf;
          end else begin
            state_nxt    = BK_WALK;
            iss_nxt      = '0;
            n_nxt        = q_cnt;
            px_nxt       = q_x;
            py_nxt       = q_y;
            snap_ovf_nxt = q_ovf;
            par_nxt      = 1'b0;
          end
        end
      end
      BK_WALK: begin
        iss_nxt = iss_r + CNT_W'(1);
        if (iss_r == n_r - CNT_W'(1)) begin
          state_nxt = BK_DRAIN;
        end
      end
      BK_DRAIN: begin
        if (m_vld_r) begin
          par_nxt = par_r ^ flip;
          if (m_last_r) begin
            state_nxt   = BK_IDLE;
            out_vld_nxt = 1'b1;
            out_ins_nxt = par_r ^ flip;
            out_few_nxt = 1'b0;
            out_ovf_nxt = snap_ovf_r;
          end
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
    if (state_r == BK_WALK && m_vld_r) begin
      par_nxt = par_r ^ flip;
    end
  end

  // edge selection from the read stream; closing edge follows the last vertex
  always_comb begin
    cur_x  = ram_rdata[COORD_W-1:0];
    cur_y  = ram_rdata[COORD_W +: COORD_W];
    e_vld  = 1'b0;
    e_last = 1'b0;
    ax     = prev_x_r;
    ay     = prev_y_r;
    bx     = cur_x;
    by     = cur_y;
    if (close_r) begin
      e_vld  = 1'b1;
      e_last = 1'b1;
      bx     = first_x_r;
      by     = first_y_r;
    end else if (rd_vld_r && !rd_first_r) begin
      e_vld = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= BK_IDLE;
      rd_vld_r   <= 1'b0;
      close_r    <= 1'b0;
      d_vld_r    <= 1'b0;
      m_vld_r    <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      rd_vld_r   <= issue;
      close_r    <= rd_vld_r && rd_last_r;
      d_vld_r    <= e_vld;
      m_vld_r    <= d_vld_r;
      out_vld_r  <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    iss_r      <= iss_nxt;
    n_r        <= n_nxt;
    px_r       <= px_nxt;
    py_r       <= py_nxt;
    snap_ovf_r <= snap_ovf_nxt;
    par_r      <= par_nxt;
    out_ins_r  <= out_ins_nxt;
    out_few_r  <= out_few_nxt;
    out_ovf_r  <= out_ovf_nxt;

    rd_first_r <= (iss_r == '0);
    rd_last_r  <= (iss_r == n_r - CNT_W'(1));

    if (rd_vld_r) begin
      prev_x_r <= cur_x;
      prev_y_r <= cur_y;
      if (rd_first_r) begin
        first_x_r <= cur_x;
        first_y_r <= cur_y;
      end
    end

    d_last_r  <= e_last;
    d_cross_r <= ((by <= py_r) && (py_r < ay)) || ((ay <= py_r) && (py_r < by));
    d_neg_r   <= (ay < by);
    d_dx_r    <= DIFF_W'(px_r) - DIFF_W'(bx);
    d_aby_r   <= DIFF_W'(ay) - DIFF_W'(by);
    d_abx_r   <= DIFF_W'(ax) - DIFF_W'(bx);
    d_dyp_r   <= DIFF_W'(py_r) - DIFF_W'(by);

    m_last_r  <= d_last_r;
    m_cross_r <= d_cross_r;
    m_neg_r   <= d_neg_r;
    m_p1_r    <= PROD_W'(d_dx_r) * PROD_W'(d_aby_r);
    m_p2_r    <= PROD_W'(d_abx_r) * PROD_W'(d_dyp_r);
  end

  a_last_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (m_vld_r && m_last_r) |-> (state_r == BK_DRAIN))
    else $error("closing edge outside drain");

  a_result_after_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (m_vld_r && m_last_r) |=> out_vld_r)
    else $error("walk finished without a result");

  a_no_read_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_vld_r || d_vld_r) |-> (state_r != BK_IDLE))
    else $error("edge traffic while idle");

endmodule

>>> rtl/point_in_polygon_test_unit.sv
// Top level of the point-in-polygon test unit (even-odd rule, half-open edges).
// Clear and append transactions edit the polygon kept in a single vertex RAM, but
// are held off while any test is queued or being walked. Test transactions enter a
// two-entry queue; the edge walker then reads one vertex per cycle from the RAM's
// single read port. A test on fewer than three vertices is answered with the
// too-few flag set and no walk. Each result sits in an output register until
// taken. No clearing pass is needed after reset: only entries below the vertex
// count are ever read.
module point_in_polygon_test_unit import pipt_pkg::*; #(
  parameter int MAX_VERTICES = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  pipt_in_if.sink     in_ch,
  pipt_out_if.source  out_ch
);

  localparam int CNT_W = $clog2(MAX_VERTICES + 1);
  localparam int AW    = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int QW    = 1 + CNT_W + VTX_W;

  logic             q_push, q_full, q_pop, q_valid;
  logic [QW-1:0]    q_din, q_dout;
  logic             back_busy;
  logic             ram_we;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [VTX_W-1:0] ram_wdata, ram_rdata;

  pipt_front #(.MAX_VERTICES(MAX_VERTICES)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .back_busy (back_busy),
    .q_full    (q_full),
    .q_valid   (q_valid),
    .q_push    (q_push),
    .q_din     (q_din),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata)
  );

  pipt_fifo #(.W(QW)) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .valid (q_valid),
    .dout  (q_dout)
  );

  pipt_ram #(.W(VTX_W), .DEPTH(MAX_VERTICES)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  pipt_back #(.MAX_VERTICES(MAX_VERTICES)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_dout    (q_dout),
    .q_pop     (q_pop),
    .busy      (back_busy),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .out_ch    (out_ch)
  );

endmodule
